// File: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Item mode codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] CFG_WIRE_MODE     = 2'd1;
  localparam logic [1:0] CFG_STEP_INTERVAL = 2'd2;

  // Coil wiring codes
  localparam logic [1:0] WIRE_TWO  = 2'd0;
  localparam logic [1:0] WIRE_FOUR = 2'd1;
  localparam logic [1:0] WIRE_FIVE = 2'd2;

  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] step_count;
  } sps_cmd_t;

  typedef struct packed {
    logic [4:0]  coil_pattern;
    logic        stepped;
    logic [15:0] position;
    logic [31:0] steps_remaining;
    logic        busy_res;
  } sps_res_t;

  // Two-wire coil table
  function automatic logic [4:0] two_wire_coil(input logic [1:0] idx);
    logic [4:0] c;
    case (idx)
      2'd0:    c = 5'd2;
      2'd1:    c = 5'd3;
      2'd2:    c = 5'd1;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // Four-wire coil table
  function automatic logic [4:0] four_wire_coil(input logic [1:0] idx);
    logic [4:0] c;
    case (idx)
      2'd0:    c = 5'd5;
      2'd1:    c = 5'd6;
      2'd2:    c = 5'd10;
      default: c = 5'd9;
    endcase
    return c;
  endfunction

  // Five-wire coil table, ten phases
  function automatic logic [4:0] five_wire_coil(input logic [3:0] idx);
    logic [4:0] c;
    case (idx)
      4'd0:    c = 5'd22;
      4'd1:    c = 5'd18;
      4'd2:    c = 5'd26;
      4'd3:    c = 5'd10;
      4'd4:    c = 5'd11;
      4'd5:    c = 5'd9;
      4'd6:    c = 5'd13;
      4'd7:    c = 5'd5;
      4'd8:    c = 5'd21;
      default: c = 5'd20;
    endcase
    return c;
  endfunction

  // Value mod 10: nibble sum gives mod 5 (16 is 1 mod 5), bit 0 gives parity
  function automatic logic [3:0] mod10_32(input logic [31:0] v);
    logic [6:0] s;
    logic [4:0] f;
    logic [2:0] r5;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    f = 5'(s[6:4]) + 5'(s[3:0]);
    if (f >= 5'd20) begin
      f = f - 5'd20;
    end else if (f >= 5'd10) begin
      f = f - 5'd10;
    end
    if (f >= 5'd5) begin
      f = f - 5'd5;
    end
    r5 = f[2:0];
    return (r5[0] == v[0]) ? 4'(r5) : 4'(r5) + 4'd5;
  endfunction

endpackage

// File: rtl/sps_if.sv
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sps_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sps_pos_reduce.sv
// ----------------------------------------------------------------------------
// sps_pos_reduce
// Bit-serial remainder unit: position mod modulus, one bit per cycle.
// ----------------------------------------------------------------------------
module sps_pos_reduce #(
  parameter int PW = 16,
  parameter int MW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [MW-1:0] modulus,
  output logic          busy,
  output logic          done,
  output logic [PW-1:0] remainder
);

  localparam int CW = $clog2(PW + 1);

  logic [CW-1:0] count;
  logic [PW-1:0] dvd;
  logic [MW-1:0] modv;
  logic [MW-1:0] rem;
  logic [MW:0]   trial;
  logic [MW-1:0] rem_next;

  // Restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dvd[PW-1]};
    if (trial >= {1'b0, modv}) begin
      rem_next = MW'(trial - {1'b0, modv});
    end else begin
      rem_next = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(PW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      modv <= modulus;
      rem  <= '0;
    end else if (busy) begin
      dvd <= {dvd[PW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // Remainder is below the dividend bound, so it fits in PW bits
  assign remainder = rem[PW-1:0];

endmodule

// File: rtl/stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Stepper motor sequencer: move commands load a signed step count, timer
// ticks pace the steps and each step drives a 2/4/5-wire coil pattern.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  cmd      in   valid/ready   sps_cmd_t  {mode, step_count}
//  result   out  valid/ready   sps_res_t  {coil_pattern, stepped, position,
//                                          steps_remaining, busy_res}
//  cfg      in   cfg_wen       cfg_addr / cfg_wdata, no read-back
//
//  One word per cycle when not stalled; each word passes the state update stage,
//  then the coil lookup stage that is the output register.
//  A write to steps_per_rev starts a remainder pass during which cmd.ready is low.
//  rst is synchronous and clears all control state; cmd.ready holds low only
//  while that pass runs or the output stage is full and stalled.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer
  import sps_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  sps_if.sink                   cmd,
  sps_if.source                 result,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = POSITION_WIDTH;
  localparam int MW = ((PW > 16) ? PW : 16) + 1;
  localparam logic [MW-1:0] MOD_FULL = MW'({1'b1, {PW{1'b0}}});

  // Configuration registers
  logic [15:0] steps_per_rev;
  logic [1:0]  wire_mode;
  logic [31:0] step_interval;

  // Motion state
  logic [PW-1:0] position;
  logic [PW-1:0] pos_mod;
  logic [31:0]   pending;
  logic          dir_rev;
  logic [31:0]   elapsed;

  // Stage 1
  logic          s1_valid;
  logic          s1_stepped;
  logic [PW-1:0] s1_position;
  logic [31:0]   s1_pending;

  // Output stage
  logic        out_valid;
  logic [4:0]  coil;
  logic        out_stepped;
  logic [15:0] out_position;
  logic [31:0] out_steps_remaining;
  logic        out_busy;

  logic          reduce_start;
  logic          reduce_busy;
  logic          reduce_done;
  logic [PW-1:0] reduce_rem;

  logic          accept;
  logic          advance;
  logic [MW-1:0] modulus;
  logic [MW-1:0] q_ext;
  logic [MW-1:0] fwd_pos;
  logic [MW-1:0] rev_pos;
  logic [PW-1:0] step_pos;
  logic [31:0]   elapsed_inc;
  logic          take_step;
  logic          cmd_neg;
  logic [4:0]    coil_next;

  // Handshakes; input held off until the reduced position is loaded
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign cmd.ready  = (!s1_valid || advance) && !reduce_start && !reduce_busy &&
                      !reduce_done;
  assign accept     = cmd.valid && cmd.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev <= 16'd200;
      wire_mode     <= WIRE_FOUR;
      step_interval <= 32'hFFFF_FFFF;
      reduce_start  <= 1'b0;
    end else begin
      reduce_start <= cfg_wen && (cfg_addr == CFG_STEPS_PER_REV);
      if (cfg_wen) begin
        unique case (cfg_addr)
          CFG_STEPS_PER_REV: steps_per_rev <= cfg_wdata[15:0];
          CFG_WIRE_MODE:     wire_mode     <= cfg_wdata[1:0];
          CFG_STEP_INTERVAL: step_interval <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  assign modulus = (steps_per_rev == 16'd0) ? MOD_FULL : MW'(steps_per_rev);

  // Position reduced to the new modulus after a steps_per_rev change
  sps_pos_reduce #(
    .PW (PW),
    .MW (MW)
  ) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .start     (reduce_start),
    .dividend  (position),
    .modulus   (modulus),
    .busy      (reduce_busy),
    .done      (reduce_done),
    .remainder (reduce_rem)
  );

  // Next position from the reduced position
  always_comb begin
    q_ext   = MW'(pos_mod);
    fwd_pos = ((q_ext + 1'b1) == modulus) ? '0 : q_ext + 1'b1;
    rev_pos = (pos_mod == '0) ? modulus - 1'b1 : q_ext - 1'b1;
    step_pos = dir_rev ? rev_pos[PW-1:0] : fwd_pos[PW-1:0];
  end

  // Tick pacing
  assign elapsed_inc = (elapsed == 32'hFFFF_FFFF) ? elapsed : elapsed + 32'd1;
  assign take_step   = (pending != 32'd0) && (elapsed_inc >= step_interval);
  assign cmd_neg     = cmd.data.step_count[31];

  // Motion state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      pos_mod  <= '0;
      pending  <= '0;
      dir_rev  <= 1'b0;
      elapsed  <= '0;
    end else if (reduce_done) begin
      pos_mod <= reduce_rem;
    end else if (accept) begin
      if (cmd.data.mode == MODE_MOVE) begin
        dir_rev <= cmd_neg || (cmd.data.step_count == 32'sd0);
        pending <= cmd_neg ? 32'd0 - 32'(cmd.data.step_count)
                           : 32'(cmd.data.step_count);
        elapsed <= '0;
      end else if (take_step) begin
        position <= step_pos;
        pos_mod  <= step_pos;
        pending  <= pending - 32'd1;
        elapsed  <= '0;
      end else begin
        elapsed <= elapsed_inc;
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.data.mode == MODE_MOVE) begin
        s1_stepped  <= 1'b0;
        s1_position <= position;
        s1_pending  <= cmd_neg ? 32'd0 - 32'(cmd.data.step_count)
                               : 32'(cmd.data.step_count);
      end else if (take_step) begin
        s1_stepped  <= 1'b1;
        s1_position <= step_pos;
        s1_pending  <= pending - 32'd1;
      end else begin
        s1_stepped  <= 1'b0;
        s1_position <= position;
        s1_pending  <= pending;
      end
    end
  end

  // Coil lookup; undefined wiring code keeps the last pattern
  always_comb begin
    coil_next = coil;
    if (s1_stepped) begin
      case (wire_mode)
        WIRE_TWO:  coil_next = two_wire_coil(s1_position[1:0]);
        WIRE_FOUR: coil_next = four_wire_coil(s1_position[1:0]);
        WIRE_FIVE: coil_next = five_wire_coil(mod10_32(32'(s1_position)));
        default:   coil_next = coil;
      endcase
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      coil      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        coil      <= coil_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stepped         <= s1_stepped;
      out_position        <= 16'(s1_position);
      out_steps_remaining <= s1_pending;
      out_busy            <= (s1_pending != 32'd0);
    end
  end

  assign result.valid                = out_valid;
  assign result.data.coil_pattern    = coil;
  assign result.data.stepped         = out_stepped;
  assign result.data.position        = out_position;
  assign result.data.steps_remaining = out_steps_remaining;
  assign result.data.busy_res        = out_busy;

endmodule

// File: rtl/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks for the stepper phase sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sps_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_stepped,
  input logic [31:0] res_steps_remaining,
  input logic        res_busy
);

  // Output channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  // Busy flag agrees with the pending count
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_busy == (res_steps_remaining != 32'd0)))
    else $error("busy_res disagrees with steps_remaining");

  // A step leaves fewer than 2^31 steps pending
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stepped |-> !res_steps_remaining[31])
    else $error("steps_remaining out of range after a step");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk                 (clk),
  .rst                 (rst),
  .res_valid           (result.valid),
  .res_ready           (result.ready),
  .res_stepped         (result.data.stepped),
  .res_steps_remaining (result.data.steps_remaining),
  .res_busy            (result.data.busy_res)
);
